// ===== rtl/vpd_pkg.sv =====
// Package for the varint prefix decoder: prefix codes, field widths and
// the result record passed between the decode stage and the output register.
// No dependencies.
package vpd_pkg;

  localparam int BYTE_W   = 8;
  localparam int VALUE_W  = 64;
  localparam int LEN_W    = 4;
  localparam int DUE_W    = 4;
  localparam int OUT_DATA_W = 72;  // value + encoded_length, padded to bytes

  localparam logic [BYTE_W-1:0] PREFIX_DIRECT_MAX = 8'hfc;
  localparam logic [BYTE_W-1:0] PREFIX_U16        = 8'hfd;
  localparam logic [BYTE_W-1:0] PREFIX_U32        = 8'hfe;
  localparam logic [BYTE_W-1:0] PREFIX_U64        = 8'hff;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_TRUNCATED = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   encoded_length;
    logic               status;
  } vpd_result_t;

endpackage

// ===== rtl/vpd_decode.sv =====
// Decode stage: holds the count of payload bytes due, the accumulator and
// the length of the number in progress; produces at most one result per byte.
// Depends on vpd_pkg.
module vpd_decode import vpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              end_of_buffer,
  output logic              res_valid,
  output vpd_result_t       res
);

  logic [DUE_W-1:0]   bytes_due, bytes_due_next;
  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic [LEN_W-1:0]   total_length, total_length_next;
  logic [VALUE_W-1:0] shifted;
  logic [DUE_W-1:0]   due_dec;

  assign shifted = {accumulator[VALUE_W-BYTE_W-1:0], in_byte};
  assign due_dec = bytes_due - DUE_W'(1);

  always_comb begin
    bytes_due_next     = bytes_due;
    accumulator_next   = accumulator;
    total_length_next  = total_length;
    res_valid          = 1'b0;
    res.value          = '0;
    res.encoded_length = '0;
    res.status         = STATUS_OK;
    if (bytes_due == '0) begin
      if (in_byte <= PREFIX_DIRECT_MAX) begin
        res_valid          = 1'b1;
        res.value          = VALUE_W'(in_byte);
        res.encoded_length = LEN_W'(1);
      end else begin
        accumulator_next = '0;
        unique case (in_byte)
          PREFIX_U16: begin
            bytes_due_next    = DUE_W'(2);
            total_length_next = LEN_W'(3);
          end
          PREFIX_U32: begin
            bytes_due_next    = DUE_W'(4);
            total_length_next = LEN_W'(5);
          end
          default: begin
            bytes_due_next    = DUE_W'(8);
            total_length_next = LEN_W'(9);
          end
        endcase
        if (end_of_buffer) begin
          bytes_due_next = '0;
          res_valid      = 1'b1;
          res.status     = STATUS_TRUNCATED;
        end
      end
    end else begin
      accumulator_next = shifted;
      bytes_due_next   = due_dec;
      if (due_dec == '0) begin
        res_valid          = 1'b1;
        res.value          = shifted;
        res.encoded_length = total_length;
      end else if (end_of_buffer) begin
        bytes_due_next = '0;
        res_valid      = 1'b1;
        res.status     = STATUS_TRUNCATED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_due <= '0;
    end else if (step) begin
      bytes_due <= bytes_due_next;
    end
    if (step) begin
      accumulator  <= accumulator_next;
      total_length <= total_length_next;
    end
  end

endmodule

// ===== rtl/vpd_out_reg.sv =====
// Output register: holds one result until the downstream side takes it.
// Depends on vpd_pkg.
module vpd_out_reg import vpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  vpd_result_t           res,
  output logic                  free,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser
);

  vpd_result_t held;

  assign free         = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata = {(OUT_DATA_W-VALUE_W-LEN_W)'(0), held.encoded_length, held.value};
  assign m_axis_tuser = held.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (free) begin
      m_axis_tvalid <= load;
    end
    if (free && load) begin
      held <= res;
    end
  end

endmodule

// ===== rtl/varint_prefix_decoder_core.sv =====
// Top level of the varint prefix decoder: input register, decode stage and
// output register. Depends on vpd_pkg, vpd_decode and vpd_out_reg.
//
// Usage:
//   The slave channel carries the encoded stream one byte per transaction;
//   tlast marks the last byte available in the buffer. A byte up to 0xfc is
//   a number by itself; 0xfd, 0xfe, 0xff are followed by 2, 4 or 8 payload
//   bytes, most significant first. The master channel carries one
//   transaction per finished number (value, encoded length 1/3/5/9, tuser 0)
//   or per buffer that ended mid-number (all zero, tuser 1).
//   Throughput: one byte per cycle, sustained while the receiver keeps tready high.
//   Path: the byte that completes a number is loaded into the input register,
//   and its result then goes from the decode stage into the output register
//   once that register is free.
//   Reset (synchronous) empties both registers and returns the decoder to
//   expecting a prefix byte.
//   When the receiver stalls, the output register holds its result and the
//   input register takes one more byte; tready then drops until the output
//   register is taken.
module varint_prefix_decoder_core import vpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] in_byte
  input  logic                  s_axis_tlast,   // end_of_buffer
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [63:0] value, [67:64] encoded_length
  output logic                  m_axis_tuser    // status
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              out_free;
  logic              step;
  logic              res_valid;
  vpd_result_t       res;

  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  vpd_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .in_byte       (in_byte),
    .end_of_buffer (in_last),
    .res_valid     (res_valid),
    .res           (res)
  );

  vpd_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step && res_valid),
    .res           (res),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== rtl/vpd_checker.sv =====
// Port-level checks for the varint prefix decoder, bound to the top level.
// Depends on vpd_pkg and varint_prefix_decoder_core.
module vpd_checker import vpd_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  a_reset_empty: assert property (@(posedge clk) !rst && $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_trunc_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("truncation result not zero");

  a_len_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[67:64] == 4'd1 || m_axis_tdata[67:64] == 4'd3 ||
      m_axis_tdata[67:64] == 4'd5 || m_axis_tdata[67:64] == 4'd9)
    else $error("illegal encoded length");

  a_direct_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser && m_axis_tdata[67:64] == 4'd1 |->
      m_axis_tdata[63:8] == '0 && m_axis_tdata[7:0] <= PREFIX_DIRECT_MAX)
    else $error("one-byte number out of range");

endmodule

bind varint_prefix_decoder_core vpd_checker u_vpd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
